// ===== rtl/sps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the seven-point stencil engine
// Widths of the grid coordinates, the store address, the Q16.16 datapath
// and the wide accumulator, plus the control word of the shared MAC unit.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int GRID_DIM = 16;
	localparam int COORD_W  = $clog2(GRID_DIM);
	localparam int ADDR_W   = 3 * COORD_W;
	localparam int CELLS    = GRID_DIM * GRID_DIM * GRID_DIM;
	localparam int VALUE_W  = 32;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = 2 * VALUE_W;
	// seven products, one residual subtract and sign: six guard bits
	localparam int ACC_W    = PROD_W + 6;

	// stencil points in the order they are read
	typedef enum logic [2:0] {
		PT_CENTER = 3'd0,
		PT_WEST   = 3'd1,
		PT_EAST   = 3'd2,
		PT_SOUTH  = 3'd3,
		PT_NORTH  = 3'd4,
		PT_BOTTOM = 3'd5,
		PT_TOP    = 3'd6
	} pt_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_HALO = 2'd2
	} stat_t;

	typedef enum logic {
		MODE_LOAD    = 1'b0,
		MODE_COMPUTE = 1'b1
	} mode_t;

	// control word for the shared multiply-accumulate unit
	typedef struct packed {
		logic clr;    // clear the accumulator
		logic vld;    // operands valid this cycle
		logic sub;    // subtract the product instead of adding it
		logic resid;  // replace acc with (y << FRAC_W) - acc
	} mac_ctl_t;

	// store address of one stencil point around cell (i, j, k)
	function automatic logic [ADDR_W-1:0] point_addr(
		input logic [COORD_W-1:0] ci,
		input logic [COORD_W-1:0] cj,
		input logic [COORD_W-1:0] ck,
		input pt_t                p
	);
		logic [COORD_W-1:0] ai, aj, ak;
		ai = ci;
		aj = cj;
		ak = ck;
		unique case (p)
			PT_WEST:   ai = ci - COORD_W'(1);
			PT_EAST:   ai = ci + COORD_W'(1);
			PT_SOUTH:  aj = cj - COORD_W'(1);
			PT_NORTH:  aj = cj + COORD_W'(1);
			PT_BOTTOM: ak = ck - COORD_W'(1);
			PT_TOP:    ak = ck + COORD_W'(1);
			default:   ai = ci;
		endcase
		return {ai, aj, ak};
	endfunction

endpackage

// ===== rtl/seven_point_stencil_residual.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_point_stencil_residual: 7-point stencil row product / residual
// Q16.16 vector store plus one shared multiply-accumulate unit run by a
// small sequencer.
// ----------------------------------------------------------------------------
// A load word (mode 0) writes x at (cell_i, cell_j, cell_k) at acceptance
// and leaves in_ready high. A compute word (mode 1) reads the seven stencil
// points from the single-port x store, one per cycle, feeds each through the
// shared multiplier and accumulator, optionally forms y - A*x (op_kind 1),
// rounds half up to Q16.16 and saturates; in_ready is low from acceptance
// until the result is placed in the output register, through the seven store
// reads, the multiply and accumulate of the last point, a check that the
// multiply pipeline is empty and the registering of the result; op_kind 1
// adds a step to form y - A*x. A compute word on a halo cell returns result
// 0, status 2 without reading the store. The output register lets the next
// word be accepted while a result waits; a result finishing while the
// register is still full waits for out_ready. Entries of the store read
// before they were written return arbitrary data. The user must write
// op_kind only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module seven_point_stencil_residual (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               mode,
	input  logic [sps_pkg::COORD_W-1:0]        cell_i,
	input  logic [sps_pkg::COORD_W-1:0]        cell_j,
	input  logic [sps_pkg::COORD_W-1:0]        cell_k,
	input  logic signed [sps_pkg::VALUE_W-1:0] value,
	input  logic signed [sps_pkg::VALUE_W-1:0] coef_center,
	input  logic signed [sps_pkg::VALUE_W-1:0] coef_west,
	input  logic signed [sps_pkg::VALUE_W-1:0] coef_east,
	input  logic signed [sps_pkg::VALUE_W-1:0] coef_south,
	input  logic signed [sps_pkg::VALUE_W-1:0] coef_north,
	input  logic signed [sps_pkg::VALUE_W-1:0] coef_bottom,
	input  logic signed [sps_pkg::VALUE_W-1:0] coef_top,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [sps_pkg::VALUE_W-1:0] result,
	output logic [1:0]                         status
);
	import sps_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DRAIN,
		S_RESID,
		S_DONE
	} state_t;

	localparam logic [COORD_W-1:0] EDGE_HI = COORD_W'(GRID_DIM - 1);

	state_t                   state_q;
	logic                     op_kind_q;
	logic                     halo_q;
	logic [2:0]               cnt_q;
	logic [COORD_W-1:0]       ci_q, cj_q, ck_q;
	logic signed [VALUE_W-1:0] y_q;
	logic signed [VALUE_W-1:0] coef_q [0:6];
	logic                     rvld_s1;
	logic [2:0]               idx_s1;
	logic                     out_valid_q;
	logic signed [VALUE_W-1:0] result_q;
	stat_t                    status_q;

	logic                     accept;
	logic                     is_halo;
	logic                     mem_we;
	logic                     mem_re;
	logic [ADDR_W-1:0]        mem_addr;
	logic [VALUE_W-1:0]       mem_rdata;
	logic signed [VALUE_W-1:0] coef_sel;
	mac_ctl_t                 mac_ctl;
	logic                     mac_busy;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  rnd;
	logic [ACC_W-FRAC_W-1:0]  shifted;
	logic [ACC_W-FRAC_W-VALUE_W:0] top_bits;
	logic                     fits;
	logic                     out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign is_halo = (cell_i == '0) || (cell_j == '0) || (cell_k == '0) ||
		(cell_i >= EDGE_HI) || (cell_j >= EDGE_HI) || (cell_k >= EDGE_HI);

	// store port: load words write at acceptance, the sequencer reads
	assign mem_we   = accept && (mode == MODE_LOAD);
	assign mem_re   = (state_q == S_READ);
	assign mem_addr = mem_we ? {cell_i, cell_j, cell_k}
		: point_addr(ci_q, cj_q, ck_q, pt_t'(cnt_q));

	sps_xmem u_xmem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (value),
		.rdata (mem_rdata)
	);

	// pick the coefficient that matches the word coming out of the store
	always_comb begin
		unique case (pt_t'(idx_s1))
			PT_CENTER: coef_sel = coef_q[PT_CENTER];
			PT_WEST:   coef_sel = coef_q[PT_WEST];
			PT_EAST:   coef_sel = coef_q[PT_EAST];
			PT_SOUTH:  coef_sel = coef_q[PT_SOUTH];
			PT_NORTH:  coef_sel = coef_q[PT_NORTH];
			PT_BOTTOM: coef_sel = coef_q[PT_BOTTOM];
			PT_TOP:    coef_sel = coef_q[PT_TOP];
			default:   coef_sel = coef_q[PT_CENTER];
		endcase
	end

	always_comb begin
		mac_ctl.clr   = accept && (mode == MODE_COMPUTE);
		mac_ctl.vld   = rvld_s1;
		mac_ctl.sub   = (idx_s1 != 3'(PT_CENTER));
		mac_ctl.resid = (state_q == S_RESID);
	end

	sps_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (coef_sel),
		.xval   ($signed(mem_rdata)),
		.yval   (y_q),
		.busy   (mac_busy),
		.acc    (acc)
	);

	// round half up, drop fraction bits, check the signed range
	assign rnd      = acc + ACC_W'(1 << (FRAC_W - 1));
	assign shifted  = rnd[ACC_W-1:FRAC_W];
	assign top_bits = shifted[ACC_W-FRAC_W-1:VALUE_W-1];
	assign fits     = (&top_bits) || !(|top_bits);

	// latch operands of an accepted compute word
	always_ff @(posedge clk) begin
		if (accept && (mode == MODE_COMPUTE)) begin
			ci_q      <= cell_i;
			cj_q      <= cell_j;
			ck_q      <= cell_k;
			y_q       <= value;
			coef_q[0] <= coef_center;
			coef_q[1] <= coef_west;
			coef_q[2] <= coef_east;
			coef_q[3] <= coef_south;
			coef_q[4] <= coef_north;
			coef_q[5] <= coef_bottom;
			coef_q[6] <= coef_top;
		end
		idx_s1 <= cnt_q;
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			if (halo_q) begin
				result_q <= '0;
				status_q <= ST_HALO;
			end else if (fits) begin
				result_q <= shifted[VALUE_W-1:0];
				status_q <= ST_OK;
			end else begin
				result_q <= rnd[ACC_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
					: {1'b0, {(VALUE_W-1){1'b1}}};
				status_q <= ST_SAT;
			end
		end
	end

	// sequencer, config register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_kind_q   <= 1'b0;
			halo_q      <= 1'b0;
			cnt_q       <= '0;
			rvld_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				op_kind_q <= cfg_wdata;
			end
			rvld_s1 <= mem_re;
			// drop the word once taken, unless a finishing result refills it
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept && (mode == MODE_COMPUTE)) begin
						halo_q  <= is_halo;
						state_q <= is_halo ? S_DONE : S_READ;
					end
				end
				S_READ: begin
					// advance one stencil point per cycle
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'(PT_TOP)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!rvld_s1 && !mac_busy) begin
						state_q <= op_kind_q ? S_RESID : S_DONE;
					end
				end
				S_RESID: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign status    = status_q;

	// a compute word always holds in_ready low in the cycle after its acceptance
	a_compute_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode == MODE_COMPUTE) |=> !in_ready)
		else $error("input taken right after a compute word");

	// no store read is in flight while idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !rvld_s1 && !mac_busy)
		else $error("multiply pipeline active while idle");

	// a refused halo cell reports zero
	a_halo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_HALO) |-> (result == '0))
		else $error("halo status with nonzero result");

endmodule

// ===== rtl/sps_xmem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_xmem: vector store for x
// Single-port memory of GRID_DIM^3 Q16.16 words with a registered read.
// One write or one read per cycle.
// ----------------------------------------------------------------------------
module sps_xmem (
	input  logic                        clk,
	input  logic                        we,
	input  logic                        re,
	input  logic [sps_pkg::ADDR_W-1:0]  addr,
	input  logic [sps_pkg::VALUE_W-1:0] wdata,
	output logic [sps_pkg::VALUE_W-1:0] rdata
);
	import sps_pkg::*;

	logic [VALUE_W-1:0] mem [0:CELLS-1];

	// write or read one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/sps_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_mac: shared multiply-accumulate unit
// One signed 32x32 multiplier with a registered product, followed by a
// wide accumulator that adds or subtracts each product, and forms the
// residual from the right-hand value on request.
// ----------------------------------------------------------------------------
module sps_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sps_pkg::mac_ctl_t                  ctl,
	input  logic signed [sps_pkg::VALUE_W-1:0] coef,
	input  logic signed [sps_pkg::VALUE_W-1:0] xval,
	input  logic signed [sps_pkg::VALUE_W-1:0] yval,
	output logic                               busy,
	output logic signed [sps_pkg::ACC_W-1:0]   acc
);
	import sps_pkg::*;

	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic                     sub_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  y_ext;

	assign prod_ext = ACC_W'(prod_s2);
	assign y_ext    = {{(ACC_W - VALUE_W - FRAC_W){yval[VALUE_W-1]}}, yval,
		{FRAC_W{1'b0}}};

	// hold valid and sign of the product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			sub_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.vld;
			sub_s2 <= ctl.sub;
		end
	end

	// multiply, then register
	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			prod_s2 <= coef * xval;
		end
	end

	// accumulate products, or form the residual
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= sub_s2 ? acc_q - prod_ext : acc_q + prod_ext;
		end else if (ctl.resid) begin
			acc_q <= y_ext - acc_q;
		end
	end

	assign busy = vld_s2;
	assign acc  = acc_q;

endmodule
